// ===== hw/rtl/u8l1_pkg.sv =====
// Package for the UTF-8 to Latin-1 folding decoder.
// Holds the decoder state type, the byte class constants and the folding function.
// No dependencies.
package u8l1_pkg;

    localparam int CpWidth = 21;

    // Lead and continuation byte classes
    localparam logic [7:0] ContMask  = 8'hC0;
    localparam logic [7:0] ContMark  = 8'h80;
    localparam logic [7:0] Lead2Mask = 8'hE0;
    localparam logic [7:0] Lead2Mark = 8'hC0;
    localparam logic [7:0] Lead3Mask = 8'hF0;
    localparam logic [7:0] Lead3Mark = 8'hE0;
    localparam logic [7:0] Lead4Mask = 8'hF8;
    localparam logic [7:0] Lead4Mark = 8'hF0;

    // Punctuation code points that fold to ASCII
    localparam logic [CpWidth-1:0] CpLsquo = 21'h02018;
    localparam logic [CpWidth-1:0] CpRsquo = 21'h02019;
    localparam logic [CpWidth-1:0] CpLdquo = 21'h0201C;
    localparam logic [CpWidth-1:0] CpRdquo = 21'h0201D;
    localparam logic [CpWidth-1:0] CpEndash = 21'h02013;
    localparam logic [CpWidth-1:0] CpEmdash = 21'h02014;
    localparam logic [CpWidth-1:0] CpEllip = 21'h02026;
    localparam logic [CpWidth-1:0] CpLowest = 21'h00020;
    localparam logic [CpWidth-1:0] CpHighest = 21'h000FF;

    localparam logic [7:0] ChApos   = 8'h27;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChHyphen = 8'h2D;
    localparam logic [7:0] ChPeriod = 8'h2E;
    localparam logic [7:0] ChNone   = 8'h00;

    // Sequence state carried between words
    typedef struct packed {
        logic [1:0]         rem;
        logic [CpWidth-1:0] cp;
    } dec_state_t;

    // Result of one decode step
    typedef struct packed {
        logic       hit;
        logic [7:0] ch;
    } dec_out_t;

    // Map a finished code point to an 8-bit character, zero when it has none
    function automatic logic [7:0] fold_cp(input logic [CpWidth-1:0] cp);
        logic [7:0] ch;
        ch = ChNone;
        if (cp >= CpLowest && cp <= CpHighest)
        begin
            ch = cp[7:0];
        end
        else
        begin
            case (cp)
                CpLsquo, CpRsquo:   ch = ChApos;
                CpLdquo, CpRdquo:   ch = ChQuote;
                CpEndash, CpEmdash: ch = ChHyphen;
                CpEllip:            ch = ChPeriod;
                default:            ch = ChNone;
            endcase
        end
        return ch;
    endfunction

endpackage

// ===== hw/rtl/u8l1_step.sv =====
// One decode step: next sequence state and the optional character for one byte.
// Purely combinational. Depends on u8l1_pkg.
module u8l1_step (
    input  u8l1_pkg::dec_state_t state,
    input  logic [7:0]           text_byte,
    input  logic                 end_of_text,
    output u8l1_pkg::dec_state_t state_next,
    output u8l1_pkg::dec_out_t   result
);
    import u8l1_pkg::*;

    logic                 is_cont;
    logic                 done;
    logic [CpWidth-1:0]   cp_done;
    logic [CpWidth-1:0]   cp_shift;
    logic [1:0]           rem_dec;
    logic [7:0]           ch;
    dec_state_t           st;

    assign is_cont  = (text_byte & ContMask) == ContMark;
    assign cp_shift = {state.cp[CpWidth-7:0], text_byte[5:0]};
    assign rem_dec  = state.rem - 2'd1;

    // Sequence tracking and lead byte decode
    always_comb
    begin
        st      = state;
        done    = 1'b0;
        cp_done = '0;
        if (state.rem != 2'd0 && is_cont)
        begin
            st.rem = rem_dec;
            if (rem_dec == 2'd0)
            begin
                st.cp   = '0;
                done    = 1'b1;
                cp_done = cp_shift;
            end
            else
            begin
                st.cp = cp_shift;
            end
        end
        else
        begin
            // abandon any open sequence, then treat the byte as a lead
            st.rem = 2'd0;
            st.cp  = '0;
            if (text_byte[7] == 1'b0)
            begin
                done    = 1'b1;
                cp_done = {{(CpWidth-8){1'b0}}, text_byte};
            end
            else if ((text_byte & Lead2Mask) == Lead2Mark)
            begin
                st.rem = 2'd1;
                st.cp  = {{(CpWidth-5){1'b0}}, text_byte[4:0]};
            end
            else if ((text_byte & Lead3Mask) == Lead3Mark)
            begin
                st.rem = 2'd2;
                st.cp  = {{(CpWidth-4){1'b0}}, text_byte[3:0]};
            end
            else if ((text_byte & Lead4Mask) == Lead4Mark)
            begin
                st.rem = 2'd3;
                st.cp  = {{(CpWidth-3){1'b0}}, text_byte[2:0]};
            end
        end
        // end of text discards whatever is open
        if (end_of_text)
        begin
            st.rem = 2'd0;
            st.cp  = '0;
        end
    end

    // Fold the finished code point
    assign ch         = fold_cp(cp_done);
    assign result.hit = done && (ch != ChNone);
    assign result.ch  = ch;
    assign state_next = st;

endmodule

// ===== hw/rtl/utf8_to_latin1_folding_decoder.sv =====
// Top level of the UTF-8 to Latin-1 folding decoder.
// Input register, sequence state, decode step and output register.
// Depends on u8l1_pkg and u8l1_step.
//
// Usage:
//   Input channel: in_valid / in_stall with text_byte and end_of_text, one
//   UTF-8 byte per word. Output channel: out_valid / out_stall with
//   legacy_char, zero or one character per input word.
//   A word is taken when valid is high and stall is low at a clock edge.
//   Throughput is one input word per cycle while the receiver does not stall.
//   The word lands in the input register, the decode step and fold run in
//   one pass, and the character lands in the output register.
//   Continuation bytes and lead bytes of multibyte sequences give no
//   character; the character appears with the final byte of its sequence.
//   When the receiver stalls, the output register holds its word and the
//   input register fills; in_stall then rises until the output drains.
//   Reset clears both valid flags and the sequence state; in_stall is low
//   once reset is released.
module utf8_to_latin1_folding_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] legacy_char
);
    import u8l1_pkg::*;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       eot_reg;
    dec_state_t state_reg;
    dec_state_t state_next;
    dec_out_t   step_out;
    logic       out_valid_reg;
    logic [7:0] char_reg;
    logic       out_free;
    logic       consume;

    // Handshake control
    assign out_free = !out_valid_reg || !out_stall;
    assign consume  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= text_byte;
            eot_reg  <= end_of_text;
        end
    end

    // Decode step
    u8l1_step u_step (
        .state       (state_reg),
        .text_byte   (byte_reg),
        .end_of_text (eot_reg),
        .state_next  (state_next),
        .result      (step_out)
    );

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (consume)
        begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= consume && step_out.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && step_out.hit)
        begin
            char_reg <= step_out.ch;
        end
    end

    assign out_valid   = out_valid_reg;
    assign legacy_char = char_reg;

endmodule
